@@ rtl/pse_pkg.sv @@
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int DATA_W          = 64;

    // command codes, unused codes 9 to 15 do nothing
    localparam logic [3:0] CMD_PUSH  = 4'd0;
    localparam logic [3:0] CMD_ADD   = 4'd1;
    localparam logic [3:0] CMD_SUB   = 4'd2;
    localparam logic [3:0] CMD_MUL   = 4'd3;
    localparam logic [3:0] CMD_DIV   = 4'd4;
    localparam logic [3:0] CMD_MOD   = 4'd5;
    localparam logic [3:0] CMD_POW   = 4'd6;
    localparam logic [3:0] CMD_FACT  = 4'd7;
    localparam logic [3:0] CMD_CLEAR = 4'd8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // how the result of a command is produced
    typedef enum logic [1:0] {
        KIND_IMM  = 2'd0,
        KIND_DIV  = 2'd1,
        KIND_POW  = 2'd2,
        KIND_FACT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MSEL_ACC_BASE  = 2'd0,
        MSEL_BASE_BASE = 2'd1,
        MSEL_ACC_EX    = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     setup;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     base_load;
        logic     ex_shift;
        logic     ex_dec;
        logic     div_start;
        logic     res_acc;
        logic     res_div;
        logic     commit;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  loop_done;
        logic  acc_step;
        logic  mul_done;
        logic  div_done;
    } dp_stat_t;

endpackage

@@ rtl/pse_mul.sv @@
module pse_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  a,
    input  logic [pse_pkg::DATA_W-1:0]  b,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  product
);

    // one byte of b per cycle, low 64 bits of the product kept
    logic [pse_pkg::DATA_W-1:0] a_reg, a_next;
    logic [pse_pkg::DATA_W-1:0] b_reg, b_next;
    logic [pse_pkg::DATA_W-1:0] p_reg, p_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pse_pkg::DATA_W+7:0] pp;

    assign pp = (pse_pkg::DATA_W + 8)'(a_reg) * (pse_pkg::DATA_W + 8)'(b_reg[7:0]);

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            p_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            p_next   = p_reg + pp[pse_pkg::DATA_W-1:0];
            a_next   = {a_reg[pse_pkg::DATA_W-9:0], 8'd0};
            b_next   = {8'd0, b_reg[pse_pkg::DATA_W-1:8]};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

@@ rtl/pse_div.sv @@
module pse_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pse_pkg::DATA_W-1:0]  dividend,
    input  logic [pse_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pse_pkg::DATA_W-1:0]  quotient,
    output logic [pse_pkg::DATA_W-1:0]  remainder
);

    // restoring division on magnitudes, one quotient bit per cycle
    localparam int W = pse_pkg::DATA_W;

    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic         negq_reg, negq_next;
    logic         negr_reg, negr_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [W-1:0] shifted;
    logic [W:0]   diff;

    assign shifted = {rem_reg[W-2:0], quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[W-1] ? (~divisor + 1'b1) : divisor;
            rem_next  = '0;
            negq_next = dividend[W-1] ^ divisor[W-1];
            negr_next = dividend[W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done      = done_reg;
    assign quotient  = negq_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = negr_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

@@ rtl/pse_datapath.sv @@
module pse_datapath
#(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  pse_pkg::ctrl_cmd_t          cmd,
    output pse_pkg::dp_stat_t           stat,
    input  logic [3:0]                  command,
    input  logic [pse_pkg::DATA_W-1:0]  literal,
    output logic [pse_pkg::DATA_W-1:0]  top_value,
    output logic [5:0]                  stack_level,
    output logic [1:0]                  status
);

    localparam int W   = pse_pkg::DATA_W;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int AW  = $clog2(STACK_DEPTH);

    // the top entry lives in top_reg, the entries below it in the memory
    logic [W-1:0]   mem [STACK_DEPTH];
    logic [W-1:0]   rd_reg;
    logic [W-1:0]   top_reg, top_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [3:0]     cmd_reg;
    logic [W-1:0]   lit_reg;
    logic [W-1:0]   acc_reg, acc_next;
    logic [W-1:0]   base_reg, base_next;
    logic [W-1:0]   ex_reg, ex_next;
    logic [W-1:0]   res_reg, res_next;
    pse_pkg::status_t st_reg, st_next;
    pse_pkg::kind_t   kind_reg, kind_next;

    logic [SPW-1:0] sp_m1, sp_m2;
    logic           wr_en;
    logic [W-1:0]   lhs, rhs;
    logic           sp_full, sp_lt2, sp_zero;

    logic [W-1:0]   mul_a, mul_b, mul_p, div_q, div_r;
    logic           mul_done, div_done;
    logic [SPW+5:0] level_ext;

    assign sp_m1   = sp_reg - SPW'(1);
    assign sp_m2   = sp_reg - SPW'(2);
    assign sp_full = (sp_reg == SPW'(STACK_DEPTH));
    assign sp_lt2  = (sp_reg < SPW'(2));
    assign sp_zero = (sp_reg == '0);
    assign lhs     = rd_reg;
    assign rhs     = top_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            pse_pkg::MSEL_ACC_BASE:
            begin
                mul_a = acc_reg;
                mul_b = base_reg;
            end
            pse_pkg::MSEL_BASE_BASE:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = acc_reg;
                mul_b = ex_reg;
            end
        endcase
    end

    pse_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pse_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (lhs),
        .divisor   (rhs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        acc_next  = acc_reg;
        base_next = base_reg;
        ex_next   = ex_reg;
        res_next  = res_reg;
        st_next   = st_reg;
        kind_next = kind_reg;
        top_next  = top_reg;
        sp_next   = sp_reg;
        wr_en     = 1'b0;

        if (cmd.setup)
        begin
            st_next   = pse_pkg::ST_OK;
            kind_next = pse_pkg::KIND_IMM;
            res_next  = '0;
            unique case (cmd_reg)
                pse_pkg::CMD_PUSH:
                begin
                    if (sp_full)
                        st_next = pse_pkg::ST_OVER;
                end
                pse_pkg::CMD_ADD, pse_pkg::CMD_SUB, pse_pkg::CMD_MUL,
                pse_pkg::CMD_DIV, pse_pkg::CMD_MOD, pse_pkg::CMD_POW:
                begin
                    if (sp_lt2)
                        st_next = pse_pkg::ST_UNDER;
                    else if (cmd_reg == pse_pkg::CMD_ADD)
                        res_next = lhs + rhs;
                    else if (cmd_reg == pse_pkg::CMD_SUB)
                        res_next = lhs - rhs;
                    else if (cmd_reg == pse_pkg::CMD_MUL)
                    begin
                        // a power loop with exponent one
                        kind_next = pse_pkg::KIND_POW;
                        acc_next  = lhs;
                        base_next = rhs;
                        ex_next   = W'(1);
                    end
                    else if (cmd_reg == pse_pkg::CMD_DIV || cmd_reg == pse_pkg::CMD_MOD)
                    begin
                        if (rhs == '0)
                            st_next = pse_pkg::ST_DIVZ;
                        else
                            kind_next = pse_pkg::KIND_DIV;
                    end
                    else if (!rhs[W-1])
                    begin
                        kind_next = pse_pkg::KIND_POW;
                        acc_next  = W'(1);
                        base_next = lhs;
                        ex_next   = rhs;
                    end
                    else if (lhs == '0)
                        st_next = pse_pkg::ST_DIVZ;
                    else if (lhs == W'(1))
                        res_next = W'(1);
                    else if (lhs == '1)
                        res_next = rhs[0] ? '1 : W'(1);
                end
                pse_pkg::CMD_FACT:
                begin
                    if (sp_zero)
                        st_next = pse_pkg::ST_UNDER;
                    else if ($signed(top_reg) <= $signed(W'(2)))
                        res_next = top_reg;
                    else if ($signed(top_reg) < $signed(W'(66)))
                    begin
                        kind_next = pse_pkg::KIND_FACT;
                        acc_next  = top_reg;
                        ex_next   = top_reg - W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.acc_load)
            acc_next = mul_p;
        if (cmd.base_load)
            base_next = mul_p;
        if (cmd.ex_shift)
            ex_next = {1'b0, ex_reg[W-1:1]};
        if (cmd.ex_dec)
            ex_next = ex_reg - W'(1);
        if (cmd.res_acc)
            res_next = acc_reg;
        if (cmd.res_div)
            res_next = (cmd_reg == pse_pkg::CMD_MOD) ? div_r : div_q;

        if (cmd.commit && st_reg == pse_pkg::ST_OK)
        begin
            unique case (cmd_reg)
                pse_pkg::CMD_PUSH:
                begin
                    wr_en    = !sp_zero;
                    top_next = lit_reg;
                    sp_next  = sp_reg + SPW'(1);
                end
                pse_pkg::CMD_ADD, pse_pkg::CMD_SUB, pse_pkg::CMD_MUL,
                pse_pkg::CMD_DIV, pse_pkg::CMD_MOD, pse_pkg::CMD_POW:
                begin
                    top_next = res_reg;
                    sp_next  = sp_m1;
                end
                pse_pkg::CMD_FACT:
                    top_next = res_reg;
                pse_pkg::CMD_CLEAR:
                    sp_next = '0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            st_reg   <= pse_pkg::ST_OK;
            kind_reg <= pse_pkg::KIND_IMM;
            cmd_reg  <= '0;
        end
        else
        begin
            sp_reg   <= sp_next;
            st_reg   <= st_next;
            kind_reg <= kind_next;
            if (cmd.capture)
                cmd_reg <= command;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            lit_reg <= literal;
        top_reg  <= top_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        ex_reg   <= ex_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[sp_m1[AW-1:0]] <= top_reg;
        rd_reg <= mem[sp_m2[AW-1:0]];
    end

    assign stat.kind      = kind_reg;
    assign stat.loop_done = (kind_reg == pse_pkg::KIND_POW) ? (ex_reg == '0)
                                                            : (ex_reg < W'(2));
    assign stat.acc_step  = (kind_reg == pse_pkg::KIND_POW) ? ex_reg[0] : 1'b1;
    assign stat.mul_done  = mul_done;
    assign stat.div_done  = div_done;

    assign level_ext   = {6'd0, sp_reg};
    assign top_value   = sp_zero ? '0 : top_reg;
    assign stack_level = level_ext[5:0];
    assign status      = st_reg;

endmodule

@@ rtl/pse_ctrl.sv @@
module pse_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pse_pkg::dp_stat_t   stat,
    output pse_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_STEP   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_SQR    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.setup  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                unique case (stat.kind)
                    pse_pkg::KIND_IMM:
                        state_next = S_COMMIT;
                    pse_pkg::KIND_DIV:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default:
                    begin
                        if (stat.loop_done)
                        begin
                            cmd.res_acc = 1'b1;
                            state_next  = S_COMMIT;
                        end
                        else if (stat.acc_step)
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.mul_sel   = (stat.kind == pse_pkg::KIND_POW)
                                          ? pse_pkg::MSEL_ACC_BASE : pse_pkg::MSEL_ACC_EX;
                            state_next    = S_MUL;
                        end
                        else
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.mul_sel   = pse_pkg::MSEL_BASE_BASE;
                            state_next    = S_SQR;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                if (stat.mul_done)
                begin
                    cmd.acc_load = 1'b1;
                    if (stat.kind == pse_pkg::KIND_POW)
                    begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = pse_pkg::MSEL_BASE_BASE;
                        state_next    = S_SQR;
                    end
                    else
                    begin
                        cmd.ex_dec = 1'b1;
                        state_next = S_STEP;
                    end
                end
            end
            S_SQR:
            begin
                if (stat.mul_done)
                begin
                    cmd.base_load = 1'b1;
                    cmd.ex_shift  = 1'b1;
                    state_next    = S_STEP;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.res_div = 1'b1;
                    state_next  = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/postfix_stack_evaluator.sv @@
// push, add, sub, clear and faults pass through decode, step and commit to the result
// div and mod wait in the divide state on the one-bit-per-cycle divider
// mul, pow and factorial run each multiply on the byte-serial multiplier:
// mul as a power loop with exponent one, pow by square and multiply, factorial downwards
// one item at a time; the next item is taken in the cycle after the result is taken
// reset: asynchronous, active low; empties the stack and idles the controller
module postfix_stack_evaluator
#(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // literal[63:0]
    input  logic [3:0]  s_axis_tuser,   // command[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // top_value[63:0], stack_level[69:64], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    pse_pkg::ctrl_cmd_t cmd;
    pse_pkg::dp_stat_t  stat;

    logic [63:0] top_value;
    logic [5:0]  stack_level;
    logic [1:0]  status;

    // controller: sequences decode, the multiply and divide loops and the stack update
    pse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: operand stack, top-of-stack register, shared multiplier and divider
    pse_datapath
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (s_axis_tuser),
        .literal     (s_axis_tdata),
        .top_value   (top_value),
        .stack_level (stack_level),
        .status      (status)
    );

    // result fields hold steady while the result waits
    assign m_axis_tdata = {2'b00, stack_level, top_value};
    assign m_axis_tuser = status;

endmodule
